/* hdl/xoxf_pkg.sv */
// ----------------------------------------------------------------------------
// XON/XOFF receive FIFO package
// Shared widths, reset values and codes for the receive FIFO and its ring.
// ----------------------------------------------------------------------------
package xoxf_pkg;

  // Default ring depth in bytes.
  localparam int DEPTH_DEF = 8;

  localparam int BYTE_W  = 8;
  localparam int LIMIT_W = 4;
  localparam int FILL_W  = 4;

  // Reset values of the two limit registers.
  localparam logic [LIMIT_W-1:0] UPPER_RST = 4'd6;
  localparam logic [LIMIT_W-1:0] LOWER_RST = 4'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'b1;

  // Input word kinds.
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

endpackage

/* hdl/xoxf_ring.sv */
// ----------------------------------------------------------------------------
// XON/XOFF receive FIFO byte ring
// Single-port-write, single-port-read byte memory with a registered read.
// ----------------------------------------------------------------------------
module xoxf_ring
  import xoxf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  logic [BYTE_W-1:0]         wdata,
  input  logic                      re,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output logic [BYTE_W-1:0]         rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/xon_xoff_receive_fifo_top.sv */
// ----------------------------------------------------------------------------
// XON/XOFF receive FIFO
// Receive-side byte FIFO with hysteresis flow control toward the transmitter.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata (low bit up)                        tuser
//  --------  ---------  ----------------------------------------  ----------
//  s_*       in         data_byte[7:0]                            action
//  m_*       out        out_byte[7:0], send_xoff, send_xon,       out_valid
//                       overflow, fill_level[3:0], zero pad
//  cfg_*     in         index 0 upper_limit, index 1 lower_limit  -
//
// One word is accepted per cycle when the pipeline can move. Pointers, count
// and the flow-on flag update at the accepting edge, and the ring read data is
// captured at that same edge. The result then passes from the middle stage to
// the output register once that stage can move (output empty or m_tready).
// A stage between the ring read and the output register lets one more word
// in while a result waits on m_tready; with both held, s_tready drops. Reset
// is synchronous; the ring needs no clearing since a pop only reads entries
// that were written.
//
module xon_xoff_receive_fifo_top
  import xoxf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input words.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // data_byte[7:0]
  input  logic                 s_tuser,   // action
  // Result words.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // out_byte[7:0], send_xoff, send_xon,
                                          // overflow, fill_level[3:0], pad
  output logic                 m_tuser,   // out_valid
  // Configuration writes.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_wdata
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

  // Limit registers.
  logic [LIMIT_W-1:0] upper_limit;
  logic [LIMIT_W-1:0] lower_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= UPPER_RST;
      lower_limit <= LOWER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UPPER: upper_limit <= cfg_wdata;
        REG_LOWER: lower_limit <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // Ring control state.
  logic [PW-1:0] read_pointer, read_pointer_next;
  logic [PW-1:0] write_pointer, write_pointer_next;
  logic [CW-1:0] held_count, held_count_next;
  logic          flow_on, flow_on_next;

  // Middle stage: waits for the ring read data.
  logic              a_valid;
  logic              a_pop_ok;
  logic              a_xoff;
  logic              a_xon;
  logic              a_ovf;
  logic [FILL_W-1:0] a_fill;

  // Output register.
  logic              o_valid;
  logic [BYTE_W-1:0] o_byte;
  logic              o_pop_ok;
  logic              o_xoff;
  logic              o_xon;
  logic              o_ovf;
  logic [FILL_W-1:0] o_fill;

  logic              a_move;
  logic              accept;
  logic              is_push;
  logic              full;
  logic              empty;
  logic              push_ok;
  logic              pop_ok;
  logic              xoff;
  logic              xon;
  logic [CMPW-1:0]   count_ext;
  logic [BYTE_W-1:0] rdata;

  assign a_move   = a_valid && (!o_valid || m_tready);
  assign s_tready = !a_valid || a_move;
  assign accept   = s_tvalid && s_tready;
  assign is_push  = (s_tuser == ACT_PUSH);

  assign full    = (held_count == CW'(DEPTH));
  assign empty   = (held_count == '0);
  assign push_ok = accept && is_push && !full;
  assign pop_ok  = accept && !is_push && !empty;

  always_comb begin
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    held_count_next    = held_count;
    flow_on_next       = flow_on;
    xoff               = 1'b0;
    xon                = 1'b0;
    if (push_ok) begin
      write_pointer_next = (write_pointer == PW'(DEPTH - 1)) ? '0 : write_pointer + 1'b1;
      held_count_next    = held_count + 1'b1;
    end
    if (pop_ok) begin
      read_pointer_next = (read_pointer == PW'(DEPTH - 1)) ? '0 : read_pointer + 1'b1;
      held_count_next   = held_count - 1'b1;
    end
    count_ext = CMPW'(held_count_next);
    // XOFF is checked after every push, dropped or not.
    if (accept && is_push && (count_ext > CMPW'(upper_limit))) begin
      xoff         = 1'b1;
      flow_on_next = 1'b0;
    end
    // XON only after a pop that actually removed a byte.
    if (pop_ok && (count_ext < CMPW'(lower_limit)) && !flow_on) begin
      xon          = 1'b1;
      flow_on_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      held_count    <= '0;
      flow_on       <= 1'b1;
    end else begin
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      held_count    <= held_count_next;
      flow_on       <= flow_on_next;
    end
  end

  xoxf_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (push_ok),
    .waddr (write_pointer),
    .wdata (s_tdata),
    .re    (pop_ok),
    .raddr (read_pointer),
    .rdata (rdata)
  );

  // Middle stage. The ring read data stays put while this stage is held,
  // since no new read is issued without an accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pop_ok <= pop_ok;
      a_xoff   <= xoff;
      a_xon    <= xon;
      a_ovf    <= is_push && full;
      a_fill   <= count_ext[FILL_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (a_move) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      o_byte   <= a_pop_ok ? rdata : '0;
      o_pop_ok <= a_pop_ok;
      o_xoff   <= a_xoff;
      o_xon    <= a_xon;
      o_ovf    <= a_ovf;
      o_fill   <= a_fill;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tuser  = o_pop_ok;
  assign m_tdata  = {1'b0, o_fill, o_ovf, o_xon, o_xoff, o_byte};

  // Assertions.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(DEPTH))
    else $error("held count above ring depth");

  a_xon_xoff_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
    else $error("XON and XOFF requested by one word");

  a_full_push_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && is_push && full) |=> $stable(held_count) && $stable(write_pointer))
    else $error("dropped push changed the ring");

  a_flow_off_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(flow_on) |-> $past(accept && is_push))
    else $error("flow turned off without a push");

  a_pop_rdy_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> !m_tdata[10])
    else $error("overflow flagged on a pop");

endmodule
